// ----- src/http_request_head_parser_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the request head parser
// Clocked on aclk, disabled while aresetn is low; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// invariant that holds at every edge
`define HRP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
    else $error("request head parser: assertion failed");
// same-cycle implication
`define HRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error("request head parser: assertion failed");
// next-cycle implication
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error("request head parser: assertion failed");
`else
`define HRP_ASSERT(lbl, prop)
`define HRP_ASSERT_IMP(lbl, ante, cons)
`define HRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/hrp_pkg.sv -----
// ---------------------------------------------------------------------------
// hrp_pkg
// Types, constants and match tables for the request head parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

    localparam int MAX_REQUEST_BYTES = 4095;
    localparam int MAX_HEADERS       = 100;
    localparam int BYTES_W           = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int HDR_W             = $clog2(MAX_HEADERS + 1);
    localparam int MAX_RES           = 3;

    localparam logic [2:0] CODE_UNKNOWN = 3'd6;
    localparam logic [2:0] CODE_BAD     = 3'd7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [3:0] {
        PH_WAIT        = 4'd0,
        PH_PRE_METHOD  = 4'd1,
        PH_METHOD      = 4'd2,
        PH_PRE_PATH    = 4'd3,
        PH_PATH        = 4'd4,
        PH_PRE_VERSION = 4'd5,
        PH_VERSION     = 4'd6,
        PH_LINE_REST   = 4'd7,
        PH_AFTER_CR    = 4'd8,
        PH_LINE_START  = 4'd9,
        PH_KEY_LEAD    = 4'd10,
        PH_KEY         = 4'd11,
        PH_VAL_FIRST   = 4'd12,
        PH_VAL_LEAD    = 4'd13,
        PH_VAL         = 4'd14,
        PH_IGNORE      = 4'd15
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] path_byte;
        logic [2:0] method_code;
        logic       persist;
        logic       request_status;
        logic       last;
    } res_t;

    // method names, padded with zeros; index = method code
    localparam logic [7:0] METH_NAME [0:5][0:7] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D",   8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T",   8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E",   "T",   "E",   8'h00, 8'h00},
        '{"O", "P", "T", "I",   "O",   "N",   "S",   8'h00}
    };
    localparam logic [2:0] METH_LEN [0:5] = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7};

    localparam logic [7:0] KEY_WORD [0:15] = '{
        "c", "o", "n", "n", "e", "c", "t", "i", "o", "n",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] VAL_WORD [0:15] = '{
        "k", "e", "e", "p", "-", "a", "l", "i", "v", "e",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [3:0] WORD_LEN = 4'd10;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] plus_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SP : c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/http_request_head_parser_unit.sv -----
// Output: the first result of an item is registered onto m_tdata in the cycle after the item is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready
// stays high; an item yielding two or three results (escape flush, summary) holds
// s_tready low until the three-entry result buffer has drained to its last entry.
// Reset: synchronous, active-low aresetn returns the parser to the start of a request
// and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

// ---------------------------------------------------------------------------
// http_request_head_parser_unit
// Byte-serial HTTP/1.1 request head parser: method class, URL-decoded path,
// keep-alive detection and an end-of-request summary.
// ---------------------------------------------------------------------------
`include "http_request_head_parser_unit_assert.svh"

module http_request_head_parser_unit
    import hrp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_request
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] path_byte, [10:8] method_code,
                                        // [11] persist, [12] request_status
    output logic             m_tuser,   // result_kind
    output logic             m_tlast    // last_of_run
);

    // parser state
    phase_t             phase_reg,    phase_next;
    logic [5:0]         cand_reg,     cand_next;
    logic [2:0]         mpos_reg,     mpos_next;
    logic [1:0]         esc_cnt_reg,  esc_cnt_next;
    logic [7:0]         esc_char_reg, esc_char_next;
    logic [3:0]         kpos_reg,     kpos_next;
    logic               km_reg,       km_next;
    logic [3:0]         vpos_reg,     vpos_next;
    logic               vm_reg,       vm_next;
    logic [HDR_W-1:0]   hdr_reg,      hdr_next;
    logic               ka_reg,       ka_next;
    logic [BYTES_W-1:0] bytes_reg,    bytes_next;

    // result buffer
    res_t               buf_reg [0:MAX_RES-1];
    res_t               buf_next [0:MAX_RES-1];
    logic [1:0]         cnt_reg, cnt_next;

    res_t               res [0:MAX_RES-1];
    logic [1:0]         res_n;

    logic [7:0]         c;
    logic               eol;
    logic               take;
    logic               end_now;
    logic               do_path;
    logic               do_flush;
    logic               rl_end;
    logic               hl_end;
    logic               force_ign;
    phase_t             after_ph;
    phase_t             line_target;
    phase_t             lp;
    logic [4:0]         h1;
    logic [4:0]         h2;
    logic               accept;
    logic               pop;

    assign c        = s_tdata;
    assign eol      = (c == CH_CR) || (c == CH_LF);
    assign after_ph = (c == CH_CR) ? PH_AFTER_CR : PH_LINE_START;
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {3'b000, buf_reg[0].request_status, buf_reg[0].persist,
                       buf_reg[0].method_code, buf_reg[0].path_byte};
    assign m_tuser  = buf_reg[0].kind;
    assign m_tlast  = buf_reg[0].last;

    always_comb begin
        phase_next    = phase_reg;
        cand_next     = cand_reg;
        mpos_next     = mpos_reg;
        esc_cnt_next  = esc_cnt_reg;
        esc_char_next = esc_char_reg;
        kpos_next     = kpos_reg;
        km_next       = km_reg;
        vpos_next     = vpos_reg;
        vm_next       = vm_reg;
        hdr_next      = hdr_reg;
        ka_next       = ka_reg;
        bytes_next    = bytes_reg;
        for (int i = 0; i < MAX_RES; i++) begin
            res[i] = '0;
        end
        res_n       = 2'd0;
        do_path     = 1'b0;
        do_flush    = 1'b0;
        rl_end      = 1'b0;
        hl_end      = 1'b0;
        force_ign   = 1'b0;
        line_target = after_ph;
        h1          = 5'd0;
        h2          = 5'd0;

        take = (phase_reg != PH_IGNORE) && (bytes_reg < BYTES_W'(MAX_REQUEST_BYTES))
               && (c != 8'h00);

        if (take) begin
            bytes_next = bytes_reg + 1'b1;
            unique case (phase_reg) inside
                PH_WAIT: begin
                    if (!eol) begin
                        cand_next = 6'h3F;
                        mpos_next = 3'd0;
                        if (c == CH_SP) begin
                            phase_next = PH_PRE_METHOD;
                        end else begin
                            for (int i = 0; i < 6; i++) begin
                                if (3'd0 >= METH_LEN[i] || METH_NAME[i][0] != c) begin
                                    cand_next[i] = 1'b0;
                                end
                            end
                            mpos_next  = 3'd1;
                            phase_next = PH_METHOD;
                        end
                    end
                end
                PH_PRE_METHOD, PH_METHOD: begin
                    if (eol) begin
                        rl_end = 1'b1;
                    end else if (c == CH_SP) begin
                        if (phase_reg == PH_METHOD) begin
                            // classify the finished method token
                            mpos_next = CODE_UNKNOWN;
                            for (int i = 0; i < 6; i++) begin
                                if (cand_reg[i] && METH_LEN[i] == mpos_reg) begin
                                    mpos_next = 3'(i);
                                end
                            end
                            phase_next = PH_PRE_PATH;
                        end
                    end else begin
                        for (int i = 0; i < 6; i++) begin
                            if (mpos_reg >= METH_LEN[i] || METH_NAME[i][mpos_reg] != c) begin
                                cand_next[i] = 1'b0;
                            end
                        end
                        if (mpos_reg != 3'd7) begin
                            mpos_next = mpos_reg + 3'd1;
                        end
                        phase_next = PH_METHOD;
                    end
                end
                PH_PRE_PATH: begin
                    if (eol) begin
                        rl_end = 1'b1;
                    end else if (c != CH_SP) begin
                        do_path    = 1'b1;
                        phase_next = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if (eol) begin
                        rl_end = 1'b1;
                    end else if (c == CH_SP) begin
                        do_flush   = 1'b1;
                        phase_next = PH_PRE_VERSION;
                    end else begin
                        do_path = 1'b1;
                    end
                end
                PH_PRE_VERSION: begin
                    if (eol) begin
                        rl_end = 1'b1;
                    end else if (c != CH_SP) begin
                        phase_next = PH_VERSION;
                    end
                end
                PH_VERSION: begin
                    if (eol) begin
                        rl_end = 1'b1;
                    end else if (c == CH_SP) begin
                        phase_next = PH_LINE_REST;
                    end
                end
                PH_LINE_REST: begin
                    if (eol) begin
                        rl_end = 1'b1;
                    end
                end
                PH_AFTER_CR, PH_LINE_START: begin
                    if (phase_reg == PH_AFTER_CR && c == CH_LF) begin
                        phase_next = PH_LINE_START;
                    end else if (eol) begin
                        // blank line ends the head
                        phase_next = PH_IGNORE;
                    end else begin
                        kpos_next = 4'd0;
                        km_next   = 1'b1;
                        vpos_next = 4'd0;
                        vm_next   = 1'b1;
                        if (c == CH_COLON) begin
                            phase_next = PH_KEY_LEAD;
                        end else begin
                            if (to_lower(c) != KEY_WORD[0]) begin
                                km_next = 1'b0;
                            end
                            kpos_next  = 4'd1;
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_KEY_LEAD, PH_KEY: begin
                    if (eol) begin
                        hl_end = 1'b1;
                    end else if (c == CH_COLON) begin
                        if (phase_reg == PH_KEY) begin
                            phase_next = PH_VAL_FIRST;
                        end
                    end else begin
                        if (kpos_reg >= WORD_LEN || to_lower(c) != KEY_WORD[kpos_reg]) begin
                            km_next = 1'b0;
                        end
                        if (kpos_reg != 4'd15) begin
                            kpos_next = kpos_reg + 4'd1;
                        end
                        phase_next = PH_KEY;
                    end
                end
                PH_VAL_FIRST, PH_VAL_LEAD, PH_VAL: begin
                    if (eol) begin
                        hl_end = 1'b1;
                    end else if (c == CH_SP && phase_reg != PH_VAL) begin
                        phase_next = PH_VAL_LEAD;
                    end else begin
                        if (vpos_reg >= WORD_LEN || to_lower(c) != VAL_WORD[vpos_reg]) begin
                            vm_next = 1'b0;
                        end
                        if (vpos_reg != 4'd15) begin
                            vpos_next = vpos_reg + 4'd1;
                        end
                        phase_next = PH_VAL;
                    end
                end
                default: begin
                end
            endcase
        end

        // percent and plus decoding of one path byte
        if (do_path) begin
            if (esc_cnt_reg == 2'd0) begin
                if (c == CH_PCT) begin
                    esc_cnt_next = 2'd1;
                end else begin
                    res[res_n].path_byte = plus_map(c);
                    res_n = res_n + 2'd1;
                end
            end else if (esc_cnt_reg == 2'd1) begin
                esc_char_next = c;
                esc_cnt_next  = 2'd2;
            end else begin
                h1 = hex_val(esc_char_reg);
                h2 = hex_val(c);
                if (h1[4]) begin
                    res[res_n].path_byte = h2[4] ? {h1[3:0], h2[3:0]} : {4'h0, h1[3:0]};
                end
                res_n        = res_n + 2'd1;
                esc_cnt_next = 2'd0;
            end
        end

        // end of data: zero byte, byte limit or flagged last byte
        end_now = (phase_next != PH_IGNORE) && (!take || bytes_next >= BYTES_W'(MAX_REQUEST_BYTES)
                  || s_tlast);
        lp = phase_next;
        if (end_now) begin
            force_ign   = 1'b1;
            line_target = PH_IGNORE;
            if (lp == PH_WAIT) begin
                mpos_next = CODE_BAD;
            end else if (lp <= PH_LINE_REST) begin
                rl_end = 1'b1;
            end else if (lp >= PH_KEY_LEAD && lp <= PH_VAL) begin
                hl_end = 1'b1;
            end
        end

        // flush a pending escape as literal text
        if (do_flush || (rl_end && lp == PH_PATH)) begin
            if (esc_cnt_next != 2'd0) begin
                res[res_n].path_byte = CH_PCT;
                res_n = res_n + 2'd1;
            end
            if (esc_cnt_next == 2'd2) begin
                res[res_n].path_byte = plus_map(esc_char_next);
                res_n = res_n + 2'd1;
            end
            esc_cnt_next  = 2'd0;
            esc_char_next = 8'h00;
        end

        if (rl_end) begin
            if (lp >= PH_VERSION && lp <= PH_LINE_REST) begin
                phase_next = line_target;
            end else begin
                mpos_next  = CODE_BAD;
                phase_next = PH_IGNORE;
            end
        end

        if (hl_end) begin
            if (lp == PH_VAL_LEAD || lp == PH_VAL) begin
                hdr_next = hdr_reg + 1'b1;
                if (km_next && kpos_next == WORD_LEN && vm_next && vpos_next == WORD_LEN) begin
                    ka_next = 1'b1;
                end
                if (hdr_next >= HDR_W'(MAX_HEADERS)) begin
                    line_target = PH_IGNORE;
                end
            end
            phase_next = line_target;
        end

        if (force_ign) begin
            phase_next = PH_IGNORE;
        end

        // summary, then back to the start of a request
        if (s_tlast) begin
            res[res_n].kind = 1'b1;
            if (mpos_next == CODE_BAD) begin
                res[res_n].method_code    = CODE_UNKNOWN;
                res[res_n].request_status = 1'b1;
            end else begin
                res[res_n].method_code = mpos_next;
                res[res_n].persist     = ka_next;
            end
            res_n = res_n + 2'd1;

            phase_next    = PH_WAIT;
            cand_next     = 6'h3F;
            mpos_next     = 3'd0;
            esc_cnt_next  = 2'd0;
            esc_char_next = 8'h00;
            kpos_next     = 4'd0;
            km_next       = 1'b1;
            vpos_next     = 4'd0;
            vm_next       = 1'b1;
            hdr_next      = '0;
            ka_next       = 1'b0;
            bytes_next    = '0;
        end

        if (res_n != 2'd0) begin
            res[res_n - 2'd1].last = 1'b1;
        end
    end

    // result buffer: load a fresh run on accept, else shift out on pop
    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next = cnt_reg;
        if (accept) begin
            for (int i = 0; i < MAX_RES; i++) begin
                buf_next[i] = res[i];
            end
            cnt_next = res_n;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT;
            cand_reg     <= 6'h3F;
            mpos_reg     <= 3'd0;
            esc_cnt_reg  <= 2'd0;
            esc_char_reg <= 8'h00;
            kpos_reg     <= 4'd0;
            km_reg       <= 1'b1;
            vpos_reg     <= 4'd0;
            vm_reg       <= 1'b1;
            hdr_reg      <= '0;
            ka_reg       <= 1'b0;
            bytes_reg    <= '0;
            cnt_reg      <= 2'd0;
        end else begin
            if (accept) begin
                phase_reg    <= phase_next;
                cand_reg     <= cand_next;
                mpos_reg     <= mpos_next;
                esc_cnt_reg  <= esc_cnt_next;
                esc_char_reg <= esc_char_next;
                kpos_reg     <= kpos_next;
                km_reg       <= km_next;
                vpos_reg     <= vpos_next;
                vm_reg       <= vm_next;
                hdr_reg      <= hdr_next;
                ka_reg       <= ka_next;
                bytes_reg    <= bytes_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

    `HRP_ASSERT(a_bytes_cap, bytes_reg <= BYTES_W'(MAX_REQUEST_BYTES))
    `HRP_ASSERT(a_hdr_cap, hdr_reg <= HDR_W'(MAX_HEADERS))
    `HRP_ASSERT_NEXT(a_last_resets, accept && s_tlast, phase_reg == PH_WAIT && bytes_reg == '0)
    `HRP_ASSERT_NEXT(a_last_summary, accept && s_tlast, m_tvalid && buf_reg[cnt_reg - 2'd1].kind)
    `HRP_ASSERT_IMP(a_run_marked, m_tvalid, buf_reg[cnt_reg - 2'd1].last)
    `HRP_ASSERT_IMP(a_code_range, m_tvalid, buf_reg[0].method_code != CODE_BAD)

endmodule

`default_nettype wire

// ----- dv/tb_http_request_head_parser_unit.sv -----
// ---------------------------------------------------------------------------
// tb_http_request_head_parser_unit
// Streams request bytes into the parser with random gaps and back-pressure.
// Each byte is run through a behavioral parser model kept in this bench. The
// model yields the decoded path bytes and the closing summary that the byte
// causes, and every result leaving the block is checked against them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_http_request_head_parser_unit;
    import hrp_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 190;
    localparam int DIRECTED_ROWS = 21;

    localparam logic       KIND_PATH    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam logic [2:0] M_PUT        = 3'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] path_byte;
        logic [2:0] meth_code;
        logic       persist;
        logic       bad;
        logic       last;
    } head_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eor;
        logic       typed;
        logic [2:0] meth_code;
        logic       persist;
        logic       bad;
    } stim_row_t;

    // summary is typed in only where it is obvious; other rows use the model
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00,  1'b1, 1'b1, CODE_UNKNOWN, 1'b0, 1'b1},
        '{8'hFF,  1'b1, 1'b1, CODE_UNKNOWN, 1'b0, 1'b1},
        '{"P",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{"U",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{"T",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_SP,  1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_PCT, 1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{"4",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_PLUS,1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_SP,  1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{"H",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_CR,  1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_LF,  1'b1, 1'b1, M_PUT,        1'b0, 1'b0},
        '{"G",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_SP,  1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_PCT, 1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{"A",    1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_LF,  1'b1, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_CR,  1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{CH_LF,  1'b0, 1'b0, 3'd0,         1'b0, 1'b0},
        '{8'h00,  1'b1, 1'b1, CODE_UNKNOWN, 1'b0, 1'b1}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // end_of_request
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] path_byte, [10:8] method_code,
                            // [11] persist, [12] request_status
    logic        m_tuser;   // result_kind
    logic        m_tlast;   // last_of_run

    http_request_head_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // parser model state
    string      meth_word [6] = '{"GET", "HEAD", "POST", "PUT", "DELETE", "OPTIONS"};
    string      conn_word     = "connection";
    string      alive_word    = "keep-alive";
    phase_t     cur_phase;
    logic [5:0] meth_live;
    logic [2:0] meth_pos;
    logic [1:0] esc_cnt;
    logic [7:0] esc_hi;
    logic [3:0] key_pos;
    logic       key_ok;
    logic [3:0] val_pos;
    logic       val_ok;
    logic [6:0] hdr_cnt;
    logic       ka_seen;
    logic [11:0] byte_cnt;

    head_result_t step_results [$];
    head_result_t expected_results [$];
    logic [7:0]   req_bytes [$];

    int unsigned fault_count = 0;
    int unsigned idle_cycles = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- parser model ----------------

    task automatic restart_parser();
        cur_phase = PH_WAIT;
        meth_live = 6'h3F;
        meth_pos  = 3'd0;
        esc_cnt   = 2'd0;
        esc_hi    = 8'h00;
        key_pos   = 4'd0;
        key_ok    = 1'b1;
        val_pos   = 4'd0;
        val_ok    = 1'b1;
        hdr_cnt   = 7'd0;
        ka_seen   = 1'b0;
        byte_cnt  = 12'd0;
    endtask

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] f;
        f = c | 8'h20;
        v = 4'h0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
            return 1'b1;
        end
        if (f >= "a" && f <= "f") begin
            v = f[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic emit_path(input logic [7:0] b);
        head_result_t r;
        r = '0;
        r.kind = KIND_PATH;
        r.path_byte = b;
        if (step_results.size() < MAX_RES) step_results.push_back(r);
    endtask

    task automatic path_char(input logic [7:0] c);
        logic [3:0] hi;
        logic [3:0] lo;
        logic       hi_ok;
        logic       lo_ok;
        if (esc_cnt == 2'd0) begin
            if (c == CH_PCT) esc_cnt = 2'd1;
            else emit_path((c == CH_PLUS) ? CH_SP : c);
        end else if (esc_cnt == 2'd1) begin
            esc_hi  = c;
            esc_cnt = 2'd2;
        end else begin
            hi_ok = hex_nibble(esc_hi, hi);
            lo_ok = hex_nibble(c, lo);
            emit_path(!hi_ok ? 8'h00 : (lo_ok ? {hi, lo} : {4'h0, hi}));
            esc_cnt = 2'd0;
        end
    endtask

    // release a pending escape as plain bytes
    task automatic flush_escape();
        if (esc_cnt != 2'd0) emit_path(CH_PCT);
        if (esc_cnt == 2'd2) emit_path((esc_hi == CH_PLUS) ? CH_SP : esc_hi);
        esc_cnt = 2'd0;
        esc_hi  = 8'h00;
    endtask

    task automatic meth_char(input logic [7:0] c);
        int i;
        for (i = 0; i < 6; i++) begin
            if (meth_pos >= meth_word[i].len() || meth_word[i][meth_pos] != c)
                meth_live[i] = 1'b0;
        end
        if (meth_pos < 3'd7) meth_pos++;
    endtask

    task automatic classify_method();
        int i;
        logic [2:0] code;
        code = CODE_UNKNOWN;
        for (i = 0; i < 6; i++) begin
            if (meth_live[i] && meth_word[i].len() == meth_pos) code = 3'(i);
        end
        meth_pos = code;
    endtask

    task automatic close_request_line(input phase_t next_ph);
        if (cur_phase == PH_PATH) flush_escape();
        if (cur_phase >= PH_VERSION && cur_phase <= PH_LINE_REST) begin
            cur_phase = next_ph;
        end else begin
            meth_pos  = CODE_BAD;
            cur_phase = PH_IGNORE;
        end
    endtask

    task automatic close_header_line(input phase_t next_ph);
        if (cur_phase == PH_VAL_LEAD || cur_phase == PH_VAL) begin
            hdr_cnt++;
            if (key_ok && key_pos == 4'd10 && val_ok && val_pos == 4'd10) ka_seen = 1'b1;
            if (hdr_cnt >= MAX_HEADERS) next_ph = PH_IGNORE;
        end
        cur_phase = next_ph;
    endtask

    task automatic key_char(input logic [7:0] c);
        if (key_pos >= 4'd10 || fold_case(c) != conn_word[key_pos]) key_ok = 1'b0;
        if (key_pos < 4'd15) key_pos++;
    endtask

    task automatic val_char(input logic [7:0] c);
        if (val_pos >= 4'd10 || fold_case(c) != alive_word[val_pos]) val_ok = 1'b0;
        if (val_pos < 4'd15) val_pos++;
    endtask

    task automatic close_data();
        if (cur_phase == PH_WAIT) begin
            meth_pos = CODE_BAD;
        end else if (cur_phase <= PH_LINE_REST) begin
            close_request_line(PH_IGNORE);
        end else if (cur_phase >= PH_KEY_LEAD && cur_phase <= PH_VAL) begin
            close_header_line(PH_IGNORE);
        end
        cur_phase = PH_IGNORE;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic   is_eol;
        phase_t after_eol;
        is_eol    = (c == CH_CR) || (c == CH_LF);
        after_eol = (c == CH_CR) ? PH_AFTER_CR : PH_LINE_START;
        case (cur_phase)
            PH_WAIT: begin
                if (!is_eol) begin
                    meth_live = 6'h3F;
                    meth_pos  = 3'd0;
                    if (c == CH_SP) begin
                        cur_phase = PH_PRE_METHOD;
                    end else begin
                        meth_char(c);
                        cur_phase = PH_METHOD;
                    end
                end
            end
            PH_PRE_METHOD: begin
                if (is_eol) close_request_line(after_eol);
                else if (c != CH_SP) begin
                    meth_char(c);
                    cur_phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                if (is_eol) close_request_line(after_eol);
                else if (c == CH_SP) begin
                    classify_method();
                    cur_phase = PH_PRE_PATH;
                end else meth_char(c);
            end
            PH_PRE_PATH: begin
                if (is_eol) close_request_line(after_eol);
                else if (c != CH_SP) begin
                    path_char(c);
                    cur_phase = PH_PATH;
                end
            end
            PH_PATH: begin
                if (is_eol) close_request_line(after_eol);
                else if (c == CH_SP) begin
                    flush_escape();
                    cur_phase = PH_PRE_VERSION;
                end else path_char(c);
            end
            PH_PRE_VERSION: begin
                if (is_eol) close_request_line(after_eol);
                else if (c != CH_SP) cur_phase = PH_VERSION;
            end
            PH_VERSION: begin
                if (is_eol) close_request_line(after_eol);
                else if (c == CH_SP) cur_phase = PH_LINE_REST;
            end
            PH_LINE_REST: begin
                if (is_eol) close_request_line(after_eol);
            end
            PH_AFTER_CR, PH_LINE_START: begin
                if (cur_phase == PH_AFTER_CR && c == CH_LF) begin
                    cur_phase = PH_LINE_START;
                end else if (is_eol) begin
                    // blank line: header scan is over
                    cur_phase = PH_IGNORE;
                end else begin
                    key_pos = 4'd0;
                    key_ok  = 1'b1;
                    val_pos = 4'd0;
                    val_ok  = 1'b1;
                    if (c == CH_COLON) begin
                        cur_phase = PH_KEY_LEAD;
                    end else begin
                        key_char(c);
                        cur_phase = PH_KEY;
                    end
                end
            end
            PH_KEY_LEAD: begin
                if (is_eol) close_header_line(after_eol);
                else if (c != CH_COLON) begin
                    key_char(c);
                    cur_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                if (is_eol) close_header_line(after_eol);
                else if (c == CH_COLON) cur_phase = PH_VAL_FIRST;
                else key_char(c);
            end
            PH_VAL_FIRST, PH_VAL_LEAD: begin
                if (is_eol) close_header_line(after_eol);
                else if (c == CH_SP) cur_phase = PH_VAL_LEAD;
                else begin
                    val_char(c);
                    cur_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                if (is_eol) close_header_line(after_eol);
                else val_char(c);
            end
            default: ;
        endcase
    endtask

    task automatic step_parser(input logic [7:0] c, input logic eor);
        head_result_t sum;
        logic         bad;
        step_results = {};
        if (cur_phase != PH_IGNORE) begin
            if (byte_cnt >= MAX_REQUEST_BYTES || c == 8'h00) begin
                close_data();
            end else begin
                byte_cnt++;
                take_char(c);
                if (byte_cnt >= MAX_REQUEST_BYTES && cur_phase != PH_IGNORE) close_data();
            end
        end
        if (eor) begin
            if (cur_phase != PH_IGNORE) close_data();
            bad = (meth_pos == CODE_BAD);
            sum = '0;
            sum.kind      = KIND_SUMMARY;
            sum.meth_code = bad ? CODE_UNKNOWN : meth_pos;
            sum.persist   = bad ? 1'b0 : ka_seen;
            sum.bad       = bad;
            if (step_results.size() < MAX_RES) step_results.push_back(sum);
            restart_parser();
        end
        if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // ---------------- driving and checking ----------------

    function automatic string show(input head_result_t r);
        return $sformatf("kind %0d byte %02h method %0d persist %0d bad %0d last %0d",
                         r.kind, r.path_byte, r.meth_code, r.persist, r.bad, r.last);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eor, input bit canned_on,
                             input head_result_t canned);
        int unsigned gap;
        if ($urandom_range(0, 23) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eor;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_parser(b, eor);
        if (canned_on) step_results[step_results.size() - 1] = canned;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    task automatic send_request();
        foreach (req_bytes[i]) send_byte(req_bytes[i], i == req_bytes.size() - 1, 1'b0, '0);
    endtask

    task automatic check_result(input head_result_t got);
        head_result_t want;
        if (expected_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("unexpected result: %s", show(got));
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.path_byte !== want.path_byte ||
                got.meth_code !== want.meth_code || got.persist !== want.persist ||
                got.bad !== want.bad || got.last !== want.last) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result mismatch: expected %s / got %s", show(want), show(got));
            end
        end
    endtask

    // ---------------- request builders ----------------

    task automatic put_text(input string s, input bit mix);
        int i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix && fold_case(c) >= "a" && fold_case(c) <= "z" && $urandom_range(0, 1) == 1)
                c = c ^ 8'h20;
            req_bytes.push_back(c);
        end
    endtask

    task automatic put_eol();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick != 8) req_bytes.push_back(CH_CR);
        if (pick != 9) req_bytes.push_back(CH_LF);
    endtask

    task automatic put_spaces();
        repeat (($urandom_range(0, 3) == 0) ? 2 : 1) req_bytes.push_back(CH_SP);
    endtask

    task automatic put_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEFgz+%";
        req_bytes.push_back(digits[$urandom_range(0, digits.len() - 1)]);
    endtask

    task automatic put_method();
        int unsigned pick;
        pick = $urandom_range(0, 8);
        if (pick < 6) begin
            put_text(meth_word[pick], 1'b0);
        end else if (pick == 6) begin
            // one letter too long
            put_text(meth_word[$urandom_range(0, 5)], 1'b0);
            put_text("S", 1'b0);
        end else if (pick == 7) begin
            put_text(meth_word[$urandom_range(0, 5)], 1'b1);
        end else begin
            repeat ($urandom_range(1, 3)) req_bytes.push_back(8'("A" + $urandom_range(0, 25)));
        end
    endtask

    task automatic put_path();
        int unsigned pick;
        logic [7:0]  c;
        if ($urandom_range(0, 4) != 0) req_bytes.push_back("/");
        repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(0, 9);
            case (pick)
                5: req_bytes.push_back(CH_PLUS);
                6: begin
                    req_bytes.push_back(CH_PCT);
                    put_hex_char();
                    put_hex_char();
                end
                7: begin
                    req_bytes.push_back(CH_PCT);
                    put_hex_char();
                end
                8: req_bytes.push_back(CH_PCT);
                9: begin
                    do c = 8'($urandom_range(1, 255));
                    while (c == CH_SP || c == CH_CR || c == CH_LF);
                    req_bytes.push_back(c);
                end
                default: req_bytes.push_back(8'("a" + $urandom_range(0, 25)));
            endcase
        end
    endtask

    task automatic put_header();
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                put_text("Connection:", 1'b1);
                repeat ($urandom_range(0, 2)) req_bytes.push_back(CH_SP);
                put_text("keep-alive", 1'b1);
            end
            3: put_text("Connection: close", 1'b1);
            4: put_text("Host: h", 1'b0);
            5: put_text("::connection:keep-alive", 1'b1);
            6: begin
                put_text("Connection:", 1'b0);
                if ($urandom_range(0, 1) == 0) put_text("  ", 1'b0);
            end
            7: put_text("Connections: keep-alive", 1'b1);
            8: put_text("Connection: keep-alived", 1'b1);
            default: begin
                if ($urandom_range(0, 1) == 1) put_text("bare", 1'b0);
                else put_text(":", 1'b0);
            end
        endcase
        put_eol();
    endtask

    task automatic build_request();
        int unsigned shape;
        int unsigned cut;
        req_bytes = {};
        if ($urandom_range(0, 9) == 0) begin
            // noise
            repeat ($urandom_range(1, 10)) req_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 4) == 0) put_eol();
        if ($urandom_range(0, 5) == 0) put_spaces();
        put_method();
        shape = $urandom_range(0, 9);
        if (shape != 0) begin
            put_spaces();
            put_path();
            if (shape != 1) begin
                put_spaces();
                put_text("HTTP/1.1", 1'b0);
                if ($urandom_range(0, 6) == 0) put_text(" x", 1'b0);
            end
        end
        put_eol();
        repeat ($urandom_range(0, 3)) put_header();
        if ($urandom_range(0, 4) != 0) put_eol();
        repeat ($urandom_range(0, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 15) == 0)
            req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'h00;
        if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, req_bytes.size());
            while (req_bytes.size() > cut) void'(req_bytes.pop_back());
        end
    endtask

    // ---------------- processes ----------------

    initial begin
        int unsigned  row;
        int unsigned  rand_items;
        head_result_t canned;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        rand_items = 0;
        restart_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            canned = '0;
            canned.kind      = KIND_SUMMARY;
            canned.meth_code = DIRECTED[row].meth_code;
            canned.persist   = DIRECTED[row].persist;
            canned.bad       = DIRECTED[row].bad;
            canned.last      = 1'b1;
            send_byte(DIRECTED[row].data, DIRECTED[row].eor, DIRECTED[row].typed, canned);
        end

        while (rand_items < RANDOM_ITEMS) begin
            build_request();
            rand_items += req_bytes.size();
            send_request();
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned  stall;
        head_result_t got;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 23) == 0) sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.kind      = m_tuser;
            got.path_byte = m_tdata[7:0];
            got.meth_code = m_tdata[10:8];
            got.persist   = m_tdata[11];
            got.bad       = m_tdata[12];
            got.last      = m_tlast;
            check_result(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
